// File: hdl/elx_pkg.sv
// elx_pkg: shared types, character codes and token codes for the expression lexer
// used by elx_scan, elx_outq and expression_lexer_top; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package elx_pkg;

  // scan modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_IDENT  = 2'd2;

  // token kinds
  localparam logic [3:0] TOK_PLUS    = 4'd0;
  localparam logic [3:0] TOK_MINUS   = 4'd1;
  localparam logic [3:0] TOK_STAR    = 4'd2;
  localparam logic [3:0] TOK_SLASH   = 4'd3;
  localparam logic [3:0] TOK_LPAR    = 4'd4;
  localparam logic [3:0] TOK_RPAR    = 4'd5;
  localparam logic [3:0] TOK_SEMI    = 4'd6;
  localparam logic [3:0] TOK_EQUALS  = 4'd7;
  localparam logic [3:0] TOK_PERCENT = 4'd8;
  localparam logic [3:0] TOK_NUMBER  = 4'd9;
  localparam logic [3:0] TOK_IDENT   = 4'd10;
  localparam logic [3:0] TOK_PRINT   = 4'd11;
  localparam logic [3:0] TOK_LET     = 4'd12;
  localparam logic [3:0] TOK_END     = 4'd13;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MULTI_DP = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

  // character codes
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LPAR    = 8'h28;
  localparam logic [7:0] CH_RPAR    = 8'h29;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // keywords
  localparam int KW_TOTAL      = 2;
  localparam int KW_PRINT_LEN  = 5;
  localparam int KW_LET_LEN    = 3;
  localparam logic [7:0] KW_PRINT [KW_PRINT_LEN] = '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74};
  localparam logic [7:0] KW_LET   [KW_LET_LEN]   = '{8'h6C, 8'h65, 8'h74};

  // result queue
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = 2;
  localparam int Q_CNT_BITS = 3;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] start_position;
    logic [9:0]  token_length;
    logic [1:0]  error_code;
    logic [7:0]  offending_byte;
    logic        last_of_run;
  } result_t;

  // up to two results produced by one item, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c == CH_UNDER) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

`default_nettype wire

// File: hdl/expression_lexer_top.sv
// expression_lexer_top: streaming tokenizer, one source byte per item in, tokens out
// depends on elx_pkg, elx_scan and elx_outq
`timescale 1ns / 1ps
`default_nettype none

// usage
//   src channel: one item per source byte (source_byte), or an end marker
//   (end_of_input = 1) that flushes the pending token and emits an end token
//   tok channel: one token or error record per item, last_of_run marks the
//   final record caused by one source item; an item causes zero, one or two
//   records
// order: the records of an item are written to the result queue when it is
//   accepted and are offered on the tok channel after any earlier records
// throughput: one source item per cycle while the queue has room for two
//   records; the four-entry result queue accepts a new item whenever it has
//   that room, and items that yield two records fill it faster than it drains
// stalls: when tok_ready is low the queue fills and src_ready drops once
//   fewer than two entries are free; nothing is lost or repeated
// reset: synchronous; lexer returns to idle, line 1, position 0, queue empty
// errors: after an error record the lexer halts; later items are still
//   accepted but give no records until reset
module expression_lexer_top #(
  parameter int MAX_TOKEN_LENGTH = 1023,
  parameter int POSITION_BITS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // source items
  input  wire logic        src_valid,
  output logic             src_ready,
  input  wire logic [7:0]  source_byte,
  input  wire logic        end_of_input,
  // token items
  output logic             tok_valid,
  input  wire logic        tok_ready,
  output logic [3:0]       token_kind,
  output logic [15:0]      line_number,
  output logic [15:0]      start_position,
  output logic [9:0]       token_length,
  output logic [1:0]       error_code,
  output logic [7:0]       offending_byte,
  output logic             last_of_run
);

  elx_pkg::push_t   push;
  elx_pkg::result_t head;
  logic             room;
  logic             take;

  // ready depends only on queue occupancy, never on scan state
  assign src_ready = room;
  assign take      = src_valid && src_ready;

  elx_scan #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
    .POSITION_BITS   (POSITION_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .source_byte (source_byte),
    .end_of_input(end_of_input),
    .push        (push)
  );

  elx_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .head     (head)
  );

  // queue head drives the token ports
  assign token_kind     = head.token_kind;
  assign line_number    = head.line_number;
  assign start_position = head.start_position;
  assign token_length   = head.token_length;
  assign error_code     = head.error_code;
  assign offending_byte = head.offending_byte;
  assign last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// File: hdl/elx_scan.sv
// elx_scan: lexer state and per-byte token logic, one item per cycle while take is high
// depends on elx_pkg
`timescale 1ns / 1ps
`default_nettype none

module elx_scan #(
  parameter int MAX_TOKEN_LENGTH = 1023,
  parameter int POSITION_BITS    = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        source_byte,
  input  wire logic              end_of_input,
  output elx_pkg::push_t         push
);

  localparam int LB = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int PB = POSITION_BITS;
  localparam logic [LB-1:0] LEN_MAX = LB'(MAX_TOKEN_LENGTH);

  logic [1:0]    mode, mode_next;
  logic          decimal_seen, decimal_seen_next;
  logic [15:0]   line_count, line_count_next;
  logic [PB-1:0] byte_position, byte_position_next;
  logic [PB-1:0] pending_start, pending_start_next;
  logic [LB-1:0] pending_length, pending_length_next;
  logic [1:0]    kw_flags, kw_flags_next;
  logic          halted, halted_next;

  logic [15:0] pos16, start16;
  logic [9:0]  len10;

  generate
    if (PB >= 16) begin : g_pos_wide
      assign pos16   = byte_position[15:0];
      assign start16 = pending_start[15:0];
    end else begin : g_pos_narrow
      assign pos16   = {{(16 - PB){1'b0}}, byte_position};
      assign start16 = {{(16 - PB){1'b0}}, pending_start};
    end
    if (LB >= 10) begin : g_len_wide
      assign len10 = pending_length[9:0];
    end else begin : g_len_narrow
      assign len10 = {{(10 - LB){1'b0}}, pending_length};
    end
  endgenerate

  logic          c_digit, c_alpha, c_dot, c_op, c_sep;
  logic [3:0]    op_kind;
  logic          print_ok, let_ok;
  logic [LB-1:0] len_grown;
  logic [15:0]   line_inc;
  logic [PB-1:0] pos_inc;
  logic [3:0]    flush_kind;
  logic          flush_valid;
  elx_pkg::result_t flush_rec, extra_rec;
  logic          extra_valid;

  always_comb begin
    c_digit = elx_pkg::is_digit(source_byte);
    c_alpha = elx_pkg::is_alpha(source_byte);
    c_dot   = (source_byte == elx_pkg::CH_DOT);
    c_sep   = (source_byte == elx_pkg::CH_SPACE) || (source_byte == elx_pkg::CH_TAB) ||
              (source_byte == elx_pkg::CH_CR);
    c_op    = 1'b1;
    case (source_byte)
      elx_pkg::CH_PLUS:    op_kind = elx_pkg::TOK_PLUS;
      elx_pkg::CH_MINUS:   op_kind = elx_pkg::TOK_MINUS;
      elx_pkg::CH_STAR:    op_kind = elx_pkg::TOK_STAR;
      elx_pkg::CH_SLASH:   op_kind = elx_pkg::TOK_SLASH;
      elx_pkg::CH_LPAR:    op_kind = elx_pkg::TOK_LPAR;
      elx_pkg::CH_RPAR:    op_kind = elx_pkg::TOK_RPAR;
      elx_pkg::CH_SEMI:    op_kind = elx_pkg::TOK_SEMI;
      elx_pkg::CH_EQUALS:  op_kind = elx_pkg::TOK_EQUALS;
      elx_pkg::CH_PERCENT: op_kind = elx_pkg::TOK_PERCENT;
      default: begin
        op_kind = elx_pkg::TOK_PLUS;
        c_op    = 1'b0;
      end
    endcase
  end

  // incremental keyword match at the current token index
  always_comb begin
    print_ok = 1'b0;
    let_ok   = 1'b0;
    for (int i = 0; i < elx_pkg::KW_PRINT_LEN; i++) begin
      if (pending_length == LB'(i) && source_byte == elx_pkg::KW_PRINT[i]) print_ok = 1'b1;
    end
    for (int i = 0; i < elx_pkg::KW_LET_LEN; i++) begin
      if (pending_length == LB'(i) && source_byte == elx_pkg::KW_LET[i]) let_ok = 1'b1;
    end
  end

  assign len_grown = (pending_length < LEN_MAX) ? pending_length + LB'(1) : pending_length;
  assign line_inc  = (line_count < 16'hFFFF) ? line_count + 16'd1 : line_count;
  assign pos_inc   = byte_position + PB'(1);

  always_comb begin
    flush_valid = (mode != elx_pkg::MODE_IDLE);
    if (mode == elx_pkg::MODE_NUMBER)
      flush_kind = elx_pkg::TOK_NUMBER;
    else if (kw_flags[0] && pending_length == LB'(elx_pkg::KW_PRINT_LEN))
      flush_kind = elx_pkg::TOK_PRINT;
    else if (kw_flags[1] && pending_length == LB'(elx_pkg::KW_LET_LEN))
      flush_kind = elx_pkg::TOK_LET;
    else
      flush_kind = elx_pkg::TOK_IDENT;
    flush_rec.token_kind     = flush_kind;
    flush_rec.line_number    = line_count;
    flush_rec.start_position = start16;
    flush_rec.token_length   = len10;
    flush_rec.error_code     = elx_pkg::ERR_NONE;
    flush_rec.offending_byte = 8'd0;
    flush_rec.last_of_run    = 1'b0;
  end

  always_comb begin
    mode_next           = mode;
    decimal_seen_next   = decimal_seen;
    line_count_next     = line_count;
    byte_position_next  = byte_position;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    kw_flags_next       = kw_flags;
    halted_next         = halted;
    push                = '0;
    extra_valid         = 1'b0;

    extra_rec.token_kind     = elx_pkg::TOK_PLUS;
    extra_rec.line_number    = line_count;
    extra_rec.start_position = pos16;
    extra_rec.token_length   = 10'd0;
    extra_rec.error_code     = elx_pkg::ERR_NONE;
    extra_rec.offending_byte = 8'd0;
    extra_rec.last_of_run    = 1'b0;

    if (take && !halted) begin
      if (end_of_input) begin
        // flush, then end token at current position
        extra_rec.token_kind = elx_pkg::TOK_END;
        extra_valid          = 1'b1;
        mode_next            = elx_pkg::MODE_IDLE;
        decimal_seen_next    = 1'b0;
        pending_length_next  = '0;
        kw_flags_next        = 2'b11;
        line_count_next      = 16'd1;
        byte_position_next   = '0;
      end else if (mode == elx_pkg::MODE_NUMBER && (c_digit || c_dot)) begin
        if (c_dot && decimal_seen) begin
          // pending number dropped, error reported, block halts
          extra_rec.error_code     = elx_pkg::ERR_MULTI_DP;
          extra_rec.offending_byte = source_byte;
          extra_valid              = 1'b1;
          mode_next                = elx_pkg::MODE_IDLE;
          decimal_seen_next        = 1'b0;
          pending_length_next      = '0;
          kw_flags_next            = 2'b11;
          halted_next              = 1'b1;
        end else begin
          decimal_seen_next   = decimal_seen | c_dot;
          pending_length_next = len_grown;
          byte_position_next  = pos_inc;
        end
      end else if (mode == elx_pkg::MODE_IDENT && (c_alpha || c_digit)) begin
        pending_length_next = len_grown;
        kw_flags_next       = kw_flags & {let_ok, print_ok};
        byte_position_next  = pos_inc;
      end else begin
        mode_next           = elx_pkg::MODE_IDLE;
        decimal_seen_next   = 1'b0;
        pending_length_next = '0;
        kw_flags_next       = 2'b11;
        byte_position_next  = pos_inc;
        if (c_op) begin
          extra_rec.token_kind   = op_kind;
          extra_rec.token_length = 10'd1;
          extra_valid            = 1'b1;
        end else if (source_byte == elx_pkg::CH_LF) begin
          line_count_next = line_inc;
        end else if (c_sep) begin
          line_count_next = line_count;
        end else if (c_digit) begin
          mode_next           = elx_pkg::MODE_NUMBER;
          pending_start_next  = byte_position;
          pending_length_next = LB'(1);
        end else if (c_alpha) begin
          mode_next           = elx_pkg::MODE_IDENT;
          pending_start_next  = byte_position;
          pending_length_next = LB'(1);
          kw_flags_next       = {source_byte == elx_pkg::KW_LET[0],
                                 source_byte == elx_pkg::KW_PRINT[0]};
        end else begin
          extra_rec.error_code     = elx_pkg::ERR_UNKNOWN;
          extra_rec.offending_byte = source_byte;
          extra_valid              = 1'b1;
          halted_next              = 1'b1;
        end
      end

      // a continuing token is not flushed; a second decimal point drops it
      if (flush_valid && !(mode == elx_pkg::MODE_NUMBER && !end_of_input &&
                           (c_digit || c_dot)) &&
          !(mode == elx_pkg::MODE_IDENT && !end_of_input && (c_alpha || c_digit))) begin
        push.first  = flush_rec;
        push.second = extra_rec;
        push.count  = extra_valid ? 2'd2 : 2'd1;
      end else begin
        push.first  = extra_rec;
        push.count  = extra_valid ? 2'd1 : 2'd0;
      end
      if (push.count == 2'd1) push.first.last_of_run = 1'b1;
      if (push.count == 2'd2) push.second.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= elx_pkg::MODE_IDLE;
      decimal_seen   <= 1'b0;
      line_count     <= 16'd1;
      byte_position  <= '0;
      pending_start  <= '0;
      pending_length <= '0;
      kw_flags       <= 2'b11;
      halted         <= 1'b0;
    end else begin
      mode           <= mode_next;
      decimal_seen   <= decimal_seen_next;
      line_count     <= line_count_next;
      byte_position  <= byte_position_next;
      pending_start  <= pending_start_next;
      pending_length <= pending_length_next;
      kw_flags       <= kw_flags_next;
      halted         <= halted_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/elx_outq.sv
// elx_outq: four-entry result queue, takes up to two results per cycle, gives one while tok_ready is high
// depends on elx_pkg
`timescale 1ns / 1ps
`default_nettype none

module elx_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire elx_pkg::push_t    push,
  output logic                   room,
  output logic                   tok_valid,
  input  wire logic              tok_ready,
  output elx_pkg::result_t       head
);

  elx_pkg::result_t mem [elx_pkg::Q_DEPTH];
  logic [elx_pkg::Q_PTR_BITS-1:0] wr_ptr, rd_ptr, wr_ptr_p1;
  logic [elx_pkg::Q_CNT_BITS-1:0] count;
  logic pop;

  assign wr_ptr_p1 = wr_ptr + elx_pkg::Q_PTR_BITS'(1);
  assign tok_valid = (count != '0);
  assign pop       = tok_valid && tok_ready;
  // room for the worst case of two results
  assign room      = (count <= elx_pkg::Q_CNT_BITS'(elx_pkg::Q_DEPTH - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr_p1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + elx_pkg::Q_PTR_BITS'(push.count);
      if (pop) rd_ptr <= rd_ptr + elx_pkg::Q_PTR_BITS'(1);
      count  <= count + elx_pkg::Q_CNT_BITS'(push.count) - elx_pkg::Q_CNT_BITS'(pop);
    end
  end

endmodule

`default_nettype wire
